@@ rtl/core/line_and_rectangle_rasterizer_unit_macros.svh @@
// Assertion macros for the rasterizer RTL.
`ifndef LINE_AND_RECTANGLE_RASTERIZER_UNIT_MACROS_SVH
`define LINE_AND_RECTANGLE_RASTERIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define LRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRR_ASSERT_NOW(label, ante, cons, msg)
`define LRR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/lrr_pkg.sv @@
// Shared types, constants and helper functions for the rasterizer.
package lrr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int CNT_BITS    = COORD_BITS + 1;
    localparam int COLOR_BITS  = 16;
    localparam int ADDR_BITS   = 32;
    localparam int STRIDE_BITS = 12;
    localparam int CMD_BITS    = 2;

    // stream word layouts
    localparam int S_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * COORD_BITS + ADDR_BITS + COLOR_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_BASE  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH = 1'd1;
    localparam logic [STRIDE_BITS-1:0]  FRAME_WIDTH_RESET = 12'd800;

    // commands / draw modes
    localparam logic [CMD_BITS-1:0] CMD_ADVANCE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LINE    = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_OUTLINE = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_FILL    = 2'd3;

    // step directions
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_PLUS  = 2'd1;
    localparam logic [1:0] DIR_MINUS = 2'd2;

    // outline sides
    localparam logic [1:0] SEG_TOP    = 2'd0;
    localparam logic [1:0] SEG_LEFT   = 2'd1;
    localparam logic [1:0] SEG_BOTTOM = 2'd2;
    localparam logic [1:0] SEG_RIGHT  = 2'd3;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [1:0]            dir_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        coord_t                sx;
        coord_t                sy;
        coord_t                ex;
        coord_t                ey;
        logic [COLOR_BITS-1:0] color;
    } cmd_word_t;

    typedef struct packed {
        logic                  valid;
        coord_t                x;
        coord_t                y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pix_t;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        dir_t   xdir;
        dir_t   ydir;
        coord_t adx;
        coord_t ady;
        coord_t major;
    } line_t;

    function automatic line_t line_setup(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        line_t l;
        l.cx = ax;
        l.cy = ay;
        if (bx > ax)
        begin
            l.xdir = DIR_PLUS;
            l.adx  = bx - ax;
        end
        else if (bx == ax)
        begin
            l.xdir = DIR_NONE;
            l.adx  = '0;
        end
        else
        begin
            l.xdir = DIR_MINUS;
            l.adx  = ax - bx;
        end
        if (by > ay)
        begin
            l.ydir = DIR_PLUS;
            l.ady  = by - ay;
        end
        else if (by == ay)
        begin
            l.ydir = DIR_NONE;
            l.ady  = '0;
        end
        else
        begin
            l.ydir = DIR_MINUS;
            l.ady  = ay - by;
        end
        l.major = (l.adx > l.ady) ? l.adx : l.ady;
        return l;
    endfunction

    function automatic coord_t move_coord(coord_t v, dir_t dir);
        coord_t r;
        case (dir)
            DIR_PLUS:  r = v + coord_t'(1);
            DIR_MINUS: r = v - coord_t'(1);
            default:   r = v;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/lrr_walker.sv @@
// Shape walker: holds the drawing state and yields one pixel per advance.
`include "line_and_rectangle_rasterizer_unit_macros.svh"

module lrr_walker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  lrr_pkg::cmd_word_t word,
    output lrr_pkg::pix_t     pix
);

    logic                           busy_reg,  busy_next;
    logic [lrr_pkg::CMD_BITS-1:0]   mode_reg,  mode_next;
    logic [1:0]                     seg_reg,   seg_next;
    lrr_pkg::coord_t                sx_reg, sx_next, sy_reg, sy_next;
    lrr_pkg::coord_t                ex_reg, ex_next, ey_reg, ey_next;
    lrr_pkg::coord_t                cx_reg, cx_next, cy_reg, cy_next;
    lrr_pkg::dir_t                  xdir_reg, xdir_next, ydir_reg, ydir_next;
    lrr_pkg::coord_t                adx_reg, adx_next, ady_reg, ady_next;
    lrr_pkg::coord_t                major_reg, major_next;
    lrr_pkg::cnt_t                  errx_reg, errx_next, erry_reg, erry_next;
    lrr_pkg::cnt_t                  cnt_reg, cnt_next;
    logic [lrr_pkg::COLOR_BITS-1:0] color_reg, color_next;

    lrr_pkg::line_t ln_new;
    logic           ln_load;
    lrr_pkg::line_t seg_line;
    lrr_pkg::cnt_t  errx_sum, erry_sum, major_ext;
    logic           line_end;
    lrr_pkg::coord_t cy_inc;
    logic [1:0]     seg_inc;

    assign major_ext = {1'b0, major_reg};
    assign errx_sum  = errx_reg + {1'b0, adx_reg};
    assign erry_sum  = erry_reg + {1'b0, ady_reg};
    assign line_end  = (cnt_reg == major_ext + lrr_pkg::cnt_t'(1));
    assign cy_inc    = cy_reg + lrr_pkg::coord_t'(1);
    assign seg_inc   = seg_reg + 2'd1;

    // next outline side, built from the stored corners
    always_comb
    begin
        case (seg_inc)
            lrr_pkg::SEG_TOP:    seg_line = lrr_pkg::line_setup(sx_reg, sy_reg, ex_reg, sy_reg);
            lrr_pkg::SEG_LEFT:   seg_line = lrr_pkg::line_setup(sx_reg, sy_reg, sx_reg, ey_reg);
            lrr_pkg::SEG_BOTTOM: seg_line = lrr_pkg::line_setup(sx_reg, ey_reg, ex_reg, ey_reg);
            default:             seg_line = lrr_pkg::line_setup(ex_reg, sy_reg, ex_reg, ey_reg);
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        mode_next  = mode_reg;
        seg_next   = seg_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        xdir_next  = xdir_reg;
        ydir_next  = ydir_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        major_next = major_reg;
        errx_next  = errx_reg;
        erry_next  = erry_reg;
        cnt_next   = cnt_reg;
        color_next = color_reg;
        ln_load    = 1'b0;
        ln_new     = seg_line;
        pix        = '0;

        if (go)
        begin
            if (word.cmd != lrr_pkg::CMD_ADVANCE)
            begin
                sx_next    = word.sx;
                sy_next    = word.sy;
                ex_next    = word.ex;
                ey_next    = word.ey;
                color_next = word.color;
                mode_next  = word.cmd;
                seg_next   = lrr_pkg::SEG_TOP;
                busy_next  = 1'b1;
                case (word.cmd)
                    lrr_pkg::CMD_LINE:
                    begin
                        ln_load = 1'b1;
                        ln_new  = lrr_pkg::line_setup(word.sx, word.sy, word.ex, word.ey);
                    end
                    lrr_pkg::CMD_OUTLINE:
                    begin
                        ln_load = 1'b1;
                        ln_new  = lrr_pkg::line_setup(word.sx, word.sy, word.ex, word.sy);
                    end
                    default:
                    begin
                        cx_next   = word.sx;
                        cy_next   = word.sy;
                        busy_next = (word.sx < word.ex) && (word.sy < word.ey);
                    end
                endcase
            end
            else if (busy_reg)
            begin
                pix.valid = 1'b1;
                pix.x     = cx_reg;
                pix.y     = cy_reg;
                pix.color = color_reg;
                if (mode_reg == lrr_pkg::CMD_FILL)
                begin
                    if (cx_reg == ex_reg - lrr_pkg::coord_t'(1) &&
                        cy_reg == ey_reg - lrr_pkg::coord_t'(1))
                    begin
                        pix.last = 1'b1;
                    end
                    else if (cy_inc == ey_reg)
                    begin
                        cy_next = sy_reg;
                        cx_next = cx_reg + lrr_pkg::coord_t'(1);
                    end
                    else
                    begin
                        cy_next = cy_inc;
                    end
                end
                else
                begin
                    // error walk, one point per advance
                    errx_next = errx_sum;
                    erry_next = erry_sum;
                    if (errx_sum > major_ext)
                    begin
                        errx_next = errx_sum - major_ext;
                        cx_next   = lrr_pkg::move_coord(cx_reg, xdir_reg);
                    end
                    if (erry_sum > major_ext)
                    begin
                        erry_next = erry_sum - major_ext;
                        cy_next   = lrr_pkg::move_coord(cy_reg, ydir_reg);
                    end
                    cnt_next = cnt_reg + lrr_pkg::cnt_t'(1);
                    if (line_end)
                    begin
                        if (mode_reg == lrr_pkg::CMD_OUTLINE && seg_reg != lrr_pkg::SEG_RIGHT)
                        begin
                            seg_next = seg_inc;
                            ln_load  = 1'b1;
                        end
                        else
                        begin
                            pix.last = 1'b1;
                        end
                    end
                end
                if (pix.last)
                begin
                    busy_next = 1'b0;
                end
            end
        end

        if (ln_load)
        begin
            cx_next    = ln_new.cx;
            cy_next    = ln_new.cy;
            xdir_next  = ln_new.xdir;
            ydir_next  = ln_new.ydir;
            adx_next   = ln_new.adx;
            ady_next   = ln_new.ady;
            major_next = ln_new.major;
            errx_next  = '0;
            erry_next  = '0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            mode_reg  <= lrr_pkg::CMD_ADVANCE;
            seg_reg   <= lrr_pkg::SEG_TOP;
            sx_reg    <= '0;
            sy_reg    <= '0;
            ex_reg    <= '0;
            ey_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            xdir_reg  <= lrr_pkg::DIR_NONE;
            ydir_reg  <= lrr_pkg::DIR_NONE;
            adx_reg   <= '0;
            ady_reg   <= '0;
            major_reg <= '0;
            errx_reg  <= '0;
            erry_reg  <= '0;
            cnt_reg   <= '0;
            color_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            mode_reg  <= mode_next;
            seg_reg   <= seg_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            ex_reg    <= ex_next;
            ey_reg    <= ey_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            xdir_reg  <= xdir_next;
            ydir_reg  <= ydir_next;
            adx_reg   <= adx_next;
            ady_reg   <= ady_next;
            major_reg <= major_next;
            errx_reg  <= errx_next;
            erry_reg  <= erry_next;
            cnt_reg   <= cnt_next;
            color_reg <= color_next;
        end
    end

    // a busy fill always has a non-empty rectangle
    `LRR_ASSERT_NOW(a_fill_nonempty, busy_reg && mode_reg == lrr_pkg::CMD_FILL, sx_reg < ex_reg && sy_reg < ey_reg, "busy fill with empty rectangle")
    // line error terms stay bounded by the major length
    `LRR_ASSERT_NOW(a_err_bounded, busy_reg && mode_reg != lrr_pkg::CMD_FILL, errx_reg <= major_ext && erry_reg <= major_ext && cnt_reg <= major_ext + lrr_pkg::cnt_t'(1), "line walk out of range")
    // last pixel ends the shape
    `LRR_ASSERT_NEXT(a_last_idles, pix.last, !busy_reg, "still busy after last pixel")
    // only the outline moves past its first side
    `LRR_ASSERT_NOW(a_seg_outline, busy_reg && mode_reg != lrr_pkg::CMD_OUTLINE, seg_reg == lrr_pkg::SEG_TOP, "side index moved outside outline mode")

endmodule

@@ rtl/core/lrr_out.sv @@
// Result register: forms the frame buffer address and holds the pixel word.
module lrr_out (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  lrr_pkg::pix_t                    pix,
    input  logic [lrr_pkg::ADDR_BITS-1:0]    frame_base,
    input  logic [lrr_pkg::STRIDE_BITS-1:0]  frame_width,
    input  logic                             ready,
    output logic                             free,
    output logic                             valid,
    output lrr_pkg::pix_t                    pix_out,
    output logic [lrr_pkg::ADDR_BITS-1:0]    addr_out
);

    logic                          valid_reg;
    lrr_pkg::pix_t                 pix_reg;
    logic [lrr_pkg::ADDR_BITS-1:0] addr_reg, addr_next;
    logic [lrr_pkg::STRIDE_BITS+lrr_pkg::COORD_BITS-1:0] row_off;

    assign row_off   = frame_width * pix.y;
    assign addr_next = frame_base + lrr_pkg::ADDR_BITS'(row_off)
                     + lrr_pkg::ADDR_BITS'(pix.x);

    assign free     = !valid_reg || ready;
    assign valid    = valid_reg;
    assign pix_out  = pix_reg;
    assign addr_out = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg  <= pix;
            addr_reg <= pix.valid ? addr_next : '0;
        end
    end

endmodule

@@ rtl/core/line_and_rectangle_rasterizer_unit.sv @@
// Top level of the line and rectangle rasterizer.
// An advance word goes through the input register, then the result register.
// Throughput: one word per cycle if m_tready keeps up, set by the input register
// feeding the walker state update and the result register for pixel and address.
// Start words produce no output; each advance word produces one output word.
// Reset (rst_n low, asynchronous) empties both registers, idles the walker,
// and sets frame_base to 0 and frame_width to 800.
module line_and_rectangle_rasterizer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lrr_pkg::S_DATA_BITS-1:0]    s_tdata,  // start_x, start_y, end_x, end_y, color
    input  logic [lrr_pkg::CMD_BITS-1:0]       s_tuser,  // command
    // output words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lrr_pkg::M_DATA_BITS-1:0]    m_tdata,  // pixel_x, pixel_y, pixel_address, pixel_color
    output logic [0:0]                         m_tuser,  // pixel_valid
    output logic                               m_tlast,  // last_pixel
    // configuration
    input  logic                               cfg_we,
    input  logic [lrr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lrr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int CB = lrr_pkg::COORD_BITS;

    logic [lrr_pkg::ADDR_BITS-1:0]   frame_base_reg;
    logic [lrr_pkg::STRIDE_BITS-1:0] frame_width_reg;

    // input register
    logic               in_valid_reg;
    lrr_pkg::cmd_word_t in_word_reg;
    lrr_pkg::cmd_word_t s_word;

    logic          out_free;
    logic          proc;
    logic          out_load;
    lrr_pkg::pix_t walk_pix;
    lrr_pkg::pix_t res_pix;
    logic [lrr_pkg::ADDR_BITS-1:0] res_addr;

    assign s_word.cmd   = s_tuser;
    assign s_word.sx    = s_tdata[CB-1:0];
    assign s_word.sy    = s_tdata[2*CB-1:CB];
    assign s_word.ex    = s_tdata[3*CB-1:2*CB];
    assign s_word.ey    = s_tdata[4*CB-1:3*CB];
    assign s_word.color = s_tdata[4*CB+lrr_pkg::COLOR_BITS-1:4*CB];

    // starts never wait on the output side; advances need a free result slot
    assign proc     = in_valid_reg
                   && (in_word_reg.cmd != lrr_pkg::CMD_ADVANCE || out_free);
    assign out_load = proc && in_word_reg.cmd == lrr_pkg::CMD_ADVANCE;
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg <= s_word;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg  <= '0;
            frame_width_reg <= lrr_pkg::FRAME_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrr_pkg::CFG_FRAME_BASE:  frame_base_reg  <= cfg_wdata;
                lrr_pkg::CFG_FRAME_WIDTH: frame_width_reg <= cfg_wdata[lrr_pkg::STRIDE_BITS-1:0];
                default: ;
            endcase
        end
    end

    lrr_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (proc),
        .word  (in_word_reg),
        .pix   (walk_pix)
    );

    lrr_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .pix         (walk_pix),
        .frame_base  (frame_base_reg),
        .frame_width (frame_width_reg),
        .ready       (m_tready),
        .free        (out_free),
        .valid       (m_tvalid),
        .pix_out     (res_pix),
        .addr_out    (res_addr)
    );

    assign m_tdata = lrr_pkg::M_DATA_BITS'({res_pix.color, res_addr, res_pix.y, res_pix.x});
    assign m_tuser = res_pix.valid;
    assign m_tlast = res_pix.last;

endmodule
